@@ hdl/dba_pkg.sv @@
// ---------------------------------------------------------------------------
// dba_pkg
// Shared constants, codes and types of the dual bitmap allocator.
// ---------------------------------------------------------------------------
package dba_pkg;

	function automatic int clog2_min1(input int n);
		return (n > 1) ? $clog2(n) : 1;
	endfunction

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// map geometry (WORD_BITS is a power of two)
	localparam int WORD_BITS      = 32;
	localparam int INODE_MAP_BITS = 4096;
	localparam int ZONE_MAP_BITS  = 65536;
	localparam int WB_LOG         = clog2_min1(WORD_BITS);

	localparam int INODE_WORDS = (INODE_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int ZONE_WORDS  = (ZONE_MAP_BITS + WORD_BITS - 1) / WORD_BITS;
	// one summary bit per data word: set when the word has nothing free
	localparam int INODE_SUMS  = (INODE_WORDS + WORD_BITS - 1) / WORD_BITS;
	localparam int ZONE_SUMS   = (ZONE_WORDS + WORD_BITS - 1) / WORD_BITS;

	localparam int IW_AW     = clog2_min1(INODE_WORDS);
	localparam int ZW_AW     = clog2_min1(ZONE_WORDS);
	localparam int WA_W      = max2(IW_AW, ZW_AW);
	localparam int IS_AW     = clog2_min1(INODE_SUMS);
	localparam int ZS_AW     = clog2_min1(ZONE_SUMS);
	localparam int SA_W      = max2(IS_AW, ZS_AW);
	localparam int CLR_WORDS = max2(INODE_WORDS, ZONE_WORDS);

	localparam int FFZ_W  = max2(WORD_BITS, max2(INODE_SUMS, ZONE_SUMS));
	localparam int FFZ_AW = clog2_min1(FFZ_W);

	// field and register widths
	localparam int OP_W          = 2;
	localparam int INDEX_W       = 16;
	localparam int NUMBER_W      = 16;
	localparam int STATUS_W      = 2;
	localparam int INODE_LIMIT_W = 13;
	localparam int ZONE_LIMIT_W  = 17;
	localparam int LIM_W         = 17;
	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 32;

	localparam logic [INODE_LIMIT_W-1:0] INODE_LIMIT_RST = INODE_LIMIT_W'(4096);
	localparam logic [ZONE_LIMIT_W-1:0]  ZONE_LIMIT_RST  = ZONE_LIMIT_W'(65536);

	// register index, from paddr[2]
	localparam logic REG_INODE_LIMIT = 1'b0;
	localparam logic REG_ZONE_LIMIT  = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_MARK  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_RANGE = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ISSUE,
		S_SUM,
		S_DATA,
		S_WB,
		S_SUMUPD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic              found;
		logic [FFZ_AW-1:0] pos;
	} ffz_res_t;

	// bits of the last summary word that stand for no real data word
	function automatic logic [WORD_BITS-1:0] sum_pad(input int nwords, input int nsums);
		logic [WORD_BITS-1:0] m;
		for (int j = 0; j < WORD_BITS; j++) begin
			m[j] = ((nsums - 1) * WORD_BITS + j >= nwords);
		end
		return m;
	endfunction

	localparam logic [WORD_BITS-1:0] INODE_SUM_PAD = sum_pad(INODE_WORDS, INODE_SUMS);
	localparam logic [WORD_BITS-1:0] ZONE_SUM_PAD  = sum_pad(ZONE_WORDS, ZONE_SUMS);

	// positions whose bit k of the index is set
	function automatic logic [FFZ_W-1:0] pos_mask(input int k);
		logic [FFZ_W-1:0] m;
		for (int i = 0; i < FFZ_W; i++) begin
			m[i] = ((i >> k) & 1) != 0;
		end
		return m;
	endfunction

endpackage

@@ hdl/dba_ffz.sv @@
// ---------------------------------------------------------------------------
// dba_ffz
// Find-first-zero unit: position of the lowest clear bit of a vector.
// ---------------------------------------------------------------------------
module dba_ffz import dba_pkg::*; (
	input  logic [FFZ_W-1:0] vec,
	output ffz_res_t         res
);

	logic [FFZ_W-1:0] free_bits;
	logic [FFZ_W-1:0] lowest;

	assign free_bits = ~vec;
	// isolate the lowest set bit of the complement
	assign lowest    = free_bits & (~free_bits + FFZ_W'(1));

	always_comb begin
		res.found = |free_bits;
		for (int k = 0; k < FFZ_AW; k++) begin
			res.pos[k] = |(lowest & pos_mask(k));
		end
	end

endmodule

@@ hdl/dual_bitmap_allocator.sv @@
// ---------------------------------------------------------------------------
// dual_bitmap_allocator
// Two free maps (inode, zone) with allocate / free / mark requests.
// ---------------------------------------------------------------------------
// Allocate: up to three find-first-zero lookups (top summary, summary word, data word)
// and a read-modify-write of the data word, then of its summary word. Free and mark
// skip the summary lookups. An allocate whose first free bit lies at or past the
// limit ends after the data-word lookup; range errors, full maps, op 3 end earlier.
// A new beat is taken only once the result is loaded; a stalled result holds it off.
// After reset a clearing pass zeroes both maps; no input beat is taken.
// ---------------------------------------------------------------------------
module dual_bitmap_allocator import dba_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [CFG_ADDR_W-1:0] paddr,
	input  logic [CFG_DATA_W-1:0] pwdata,
	output logic [CFG_DATA_W-1:0] prdata,
	output logic                  pready,
	// requests
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [OP_W-1:0]       op,
	input  logic                  map_select,
	input  logic [INDEX_W-1:0]    index,
	// results
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [NUMBER_W-1:0]   number,
	output logic [STATUS_W-1:0]   status
);

	state_t state_q, state_d;

	logic [INODE_LIMIT_W-1:0] inode_limit_q;
	logic [ZONE_LIMIT_W-1:0]  zone_limit_q;

	op_t                  op_q;
	logic                 zone_q;
	logic [INDEX_W-1:0]   idx_q;
	logic [SA_W-1:0]      s_q;
	logic [WA_W-1:0]      w_q;
	logic [WORD_BITS-1:0] newword_q;
	logic                 newfull_q;
	logic [NUMBER_W-1:0]  res_number_q;
	status_t              res_status_q;
	logic [WA_W-1:0]      clr_q;

	logic [INODE_SUMS-1:0] inode_top_q;
	logic [ZONE_SUMS-1:0]  zone_top_q;

	logic [WORD_BITS-1:0] inode_mem     [INODE_WORDS];
	logic [WORD_BITS-1:0] zone_mem      [ZONE_WORDS];
	logic [WORD_BITS-1:0] inode_sum_mem [INODE_SUMS];
	logic [WORD_BITS-1:0] zone_sum_mem  [ZONE_SUMS];
	logic [WORD_BITS-1:0] inode_rd_q, zone_rd_q, inode_sum_rd_q, zone_sum_rd_q;

	logic                out_valid_q;
	logic [NUMBER_W-1:0] number_q;
	status_t             status_q;

	// ---------------------------------------------------------------- config
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_limit_q <= INODE_LIMIT_RST;
			zone_limit_q  <= ZONE_LIMIT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_INODE_LIMIT) begin
				inode_limit_q <= pwdata[INODE_LIMIT_W-1:0];
			end else begin
				zone_limit_q <= pwdata[ZONE_LIMIT_W-1:0];
			end
		end
	end

	assign prdata = (paddr[2] == REG_ZONE_LIMIT) ? CFG_DATA_W'(zone_limit_q)
	                                             : CFG_DATA_W'(inode_limit_q);

	// ------------------------------------------------------------- datapath
	logic [LIM_W-1:0]     inode_lim_eff, zone_lim_eff, lim_eff;
	logic [WORD_BITS-1:0] word_rd, sum_rd, sum_pad_v, b0mask;
	logic [FFZ_W-1:0]     top_vec, ffz_in;
	ffz_res_t             ffz;
	logic [LIM_W-1:0]     cand_n, idx_ext;
	logic                 alloc_ok, idx_bad;
	logic [WA_W-1:0]      w_from_sum, w_from_idx;
	logic [WORD_BITS-1:0] bit_oh_alloc, bit_oh_idx, sum_oh, newsum;
	logic                 sum_full;

	assign inode_lim_eff = (LIM_W'(inode_limit_q) > LIM_W'(INODE_MAP_BITS))
	                       ? LIM_W'(INODE_MAP_BITS) : LIM_W'(inode_limit_q);
	assign zone_lim_eff  = (LIM_W'(zone_limit_q) > LIM_W'(ZONE_MAP_BITS))
	                       ? LIM_W'(ZONE_MAP_BITS) : LIM_W'(zone_limit_q);
	assign lim_eff       = zone_q ? zone_lim_eff : inode_lim_eff;

	assign word_rd = zone_q ? zone_rd_q : inode_rd_q;
	assign sum_rd  = zone_q ? zone_sum_rd_q : inode_sum_rd_q;

	always_comb begin
		sum_pad_v = '0;
		if (zone_q) begin
			if (s_q == SA_W'(ZONE_SUMS - 1)) begin
				sum_pad_v = ZONE_SUM_PAD;
			end
		end else begin
			if (s_q == SA_W'(INODE_SUMS - 1)) begin
				sum_pad_v = INODE_SUM_PAD;
			end
		end
	end

	// bit 0 of word 0 is reserved: never free for allocation
	assign b0mask = (w_q == '0) ? WORD_BITS'(1) : '0;

	always_comb begin
		top_vec = '1;
		if (zone_q) begin
			top_vec[ZONE_SUMS-1:0] = zone_top_q;
		end else begin
			top_vec[INODE_SUMS-1:0] = inode_top_q;
		end
	end

	always_comb begin
		ffz_in = '1;
		case (state_q)
			S_ISSUE: ffz_in = top_vec;
			S_SUM:   ffz_in[WORD_BITS-1:0] = sum_rd | sum_pad_v;
			S_DATA:  ffz_in[WORD_BITS-1:0] = word_rd | b0mask;
			default: ffz_in = '1;
		endcase
	end

	dba_ffz u_ffz (
		.vec (ffz_in),
		.res (ffz)
	);

	assign w_from_sum = WA_W'((WA_W'(s_q) << WB_LOG) | WA_W'(ffz.pos[WB_LOG-1:0]));
	assign w_from_idx = WA_W'(idx_q >> WB_LOG);
	assign cand_n     = (LIM_W'(w_q) << WB_LOG) | LIM_W'(ffz.pos[WB_LOG-1:0]);
	assign idx_ext    = LIM_W'(idx_q);
	assign idx_bad    = idx_ext >= lim_eff;
	assign alloc_ok   = ffz.found && (cand_n < lim_eff);

	assign bit_oh_alloc = WORD_BITS'(1) << ffz.pos[WB_LOG-1:0];
	assign bit_oh_idx   = WORD_BITS'(1) << idx_q[WB_LOG-1:0];
	assign sum_oh       = WORD_BITS'(1) << w_q[WB_LOG-1:0];
	assign newsum       = newfull_q ? (sum_rd | sum_oh) : (sum_rd & ~sum_oh);
	assign sum_full     = &(newsum | sum_pad_v);

	// ------------------------------------------------------------ sequencer
	logic            clearing;
	logic            data_we, sum_we, out_load;
	logic [WA_W-1:0] data_raddr;
	logic [SA_W-1:0] sum_raddr;

	assign clearing = (state_q == S_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_q <= clr_q + WA_W'(1);
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		data_we    = 1'b0;
		sum_we     = 1'b0;
		out_load   = 1'b0;
		data_raddr = w_q;
		sum_raddr  = s_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == WA_W'(CLR_WORDS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_ISSUE;
				end
			end
			S_ISSUE: begin
				case (op_q)
					OP_ALLOC: begin
						sum_raddr = SA_W'(ffz.pos);
						state_d   = ffz.found ? S_SUM : S_DONE;
					end
					OP_FREE, OP_MARK: begin
						data_raddr = w_from_idx;
						state_d    = idx_bad ? S_DONE : S_DATA;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SUM: begin
				data_raddr = w_from_sum;
				state_d    = ffz.found ? S_DATA : S_DONE;
			end
			S_DATA: begin
				if (op_q == OP_ALLOC && !alloc_ok) begin
					state_d = S_DONE;
				end else begin
					state_d = S_WB;
				end
			end
			S_WB: begin
				data_we   = 1'b1;
				sum_raddr = SA_W'(w_q >> WB_LOG);
				state_d   = S_SUMUPD;
			end
			S_SUMUPD: begin
				sum_we  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	// per-item registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op_q   <= op_t'(op);
					zone_q <= map_select;
					idx_q  <= index;
				end
			end
			S_ISSUE: begin
				res_number_q <= '0;
				res_status_q <= STAT_OK;
				s_q          <= SA_W'(ffz.pos);
				w_q          <= w_from_idx;
				if (op_q == OP_ALLOC && !ffz.found) begin
					res_status_q <= STAT_FULL;
				end
				if ((op_q == OP_FREE || op_q == OP_MARK) && idx_bad) begin
					res_status_q <= STAT_RANGE;
				end
			end
			S_SUM: begin
				w_q <= w_from_sum;
				if (!ffz.found) begin
					res_status_q <= STAT_FULL;
				end
			end
			S_DATA: begin
				case (op_q)
					OP_ALLOC: begin
						newword_q <= word_rd | bit_oh_alloc;
						if (alloc_ok) begin
							res_number_q <= NUMBER_W'(cand_n);
						end else begin
							res_status_q <= STAT_FULL;
						end
					end
					OP_FREE: newword_q <= word_rd & ~bit_oh_idx;
					default: newword_q <= word_rd | bit_oh_idx;
				endcase
			end
			S_WB: begin
				newfull_q <= &(newword_q | b0mask);
				s_q       <= SA_W'(w_q >> WB_LOG);
			end
			default: begin
			end
		endcase
	end

	// top-level summary: one bit per summary word, set when all its words are full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inode_top_q <= '0;
			zone_top_q  <= '0;
		end else if (state_q == S_SUMUPD) begin
			if (zone_q) begin
				zone_top_q[s_q[ZS_AW-1:0]] <= sum_full;
			end else begin
				inode_top_q[s_q[IS_AW-1:0]] <= sum_full;
			end
		end
	end

	// ------------------------------------------------------------- memories
	logic                 inode_we, zone_we, inode_sum_we, zone_sum_we;
	logic [WA_W-1:0]      data_waddr;
	logic [SA_W-1:0]      sum_waddr;
	logic [WORD_BITS-1:0] data_wdata, sum_wdata;

	assign data_waddr = clearing ? clr_q : w_q;
	assign sum_waddr  = clearing ? SA_W'(clr_q) : s_q;
	assign data_wdata = clearing ? '0 : newword_q;
	assign sum_wdata  = clearing ? '0 : newsum;

	assign inode_we     = clearing ? ({1'b0, clr_q} < (WA_W + 1)'(INODE_WORDS))
	                               : (data_we && !zone_q);
	assign zone_we      = clearing ? ({1'b0, clr_q} < (WA_W + 1)'(ZONE_WORDS))
	                               : (data_we && zone_q);
	assign inode_sum_we = clearing ? ({1'b0, clr_q} < (WA_W + 1)'(INODE_SUMS))
	                               : (sum_we && !zone_q);
	assign zone_sum_we  = clearing ? ({1'b0, clr_q} < (WA_W + 1)'(ZONE_SUMS))
	                               : (sum_we && zone_q);

	always_ff @(posedge clk) begin
		if (inode_we) begin
			inode_mem[data_waddr[IW_AW-1:0]] <= data_wdata;
		end
		inode_rd_q <= inode_mem[data_raddr[IW_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (zone_we) begin
			zone_mem[data_waddr[ZW_AW-1:0]] <= data_wdata;
		end
		zone_rd_q <= zone_mem[data_raddr[ZW_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (inode_sum_we) begin
			inode_sum_mem[sum_waddr[IS_AW-1:0]] <= sum_wdata;
		end
		inode_sum_rd_q <= inode_sum_mem[sum_raddr[IS_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (zone_sum_we) begin
			zone_sum_mem[sum_waddr[ZS_AW-1:0]] <= sum_wdata;
		end
		zone_sum_rd_q <= zone_sum_mem[sum_raddr[ZS_AW-1:0]];
	end

	// --------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			number_q <= res_number_q;
			status_q <= res_status_q;
		end
	end

	assign out_valid = out_valid_q;
	assign number    = number_q;
	assign status    = status_q;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the dual bitmap allocator. A shadow copy of both
// free maps predicts number and status for every request beat; results are
// checked in order. Limits are reprogrammed between phases, over the APB port.
// ---------------------------------------------------------------------------
module tb_top;
	import dba_pkg::*;

	typedef struct packed {
		op_t                kind;
		logic               zone;
		logic [INDEX_W-1:0] idx;
	} request_t;

	typedef struct packed {
		logic [NUMBER_W-1:0] num;
		status_t             stat;
	} outcome_t;

	typedef enum {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [OP_W-1:0]       op = '0;
	logic                  map_select = 1'b0;
	logic [INDEX_W-1:0]    index = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [NUMBER_W-1:0]   number;
	logic [STATUS_W-1:0]   status;

	dual_bitmap_allocator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.map_select (map_select),
		.index      (index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.number     (number),
		.status     (status)
	);

	always #6 clk = ~clk;

	// shadow state
	bit                       inode_used [INODE_MAP_BITS];
	bit                       zone_used [ZONE_MAP_BITS];
	logic [INODE_LIMIT_W-1:0] inode_lim_reg = INODE_LIMIT_RST;
	logic [ZONE_LIMIT_W-1:0]  zone_lim_reg = ZONE_LIMIT_RST;

	request_t pend_requests [$];
	outcome_t due_outcomes [$];
	bit       req_taken = 1'b0;
	bit       failed = 1'b0;
	int       burst_left = 0;
	int       gap_left = 0;
	int       hold_req = 0;
	int       hold_done = 0;
	int       hold_left = 0;
	int       mode_left = 0;
	int       rx_cycle = 0;
	rx_mode_t rx_mode = RX_OPEN;

	function automatic int eff_limit(bit zone);
		if (zone)
			return (zone_lim_reg > ZONE_MAP_BITS) ? ZONE_MAP_BITS : int'(zone_lim_reg);
		return (inode_lim_reg > INODE_MAP_BITS) ? INODE_MAP_BITS : int'(inode_lim_reg);
	endfunction

	function automatic bit map_bit(bit zone, int n);
		return zone ? zone_used[n] : inode_used[n];
	endfunction

	function automatic void put_bit(bit zone, int n, bit v);
		if (zone) zone_used[n] = v;
		else inode_used[n] = v;
	endfunction

	// applies one request to the shadow maps and returns its result
	function automatic outcome_t predict_outcome(request_t r);
		outcome_t res;
		int       lim;
		int       n;
		res.num  = '0;
		res.stat = STAT_OK;
		lim      = eff_limit(r.zone);
		case (r.kind)
			OP_ALLOC: begin
				// bit 0 is reserved; first clear bit below the limit
				n = 1;
				while (n < lim && map_bit(r.zone, n)) n++;
				if (n < lim) begin
					put_bit(r.zone, n, 1'b1);
					res.num = NUMBER_W'(n);
				end else begin
					res.stat = STAT_FULL;
				end
			end
			OP_FREE, OP_MARK: begin
				if (r.idx >= lim) res.stat = STAT_RANGE;
				else put_bit(r.zone, int'(r.idx), r.kind == OP_MARK);
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic void queue_req(op_t k, bit zone, int idx);
		request_t r;
		r.kind = k;
		r.zone = zone;
		r.idx  = INDEX_W'(idx);
		pend_requests.push_back(r);
	endfunction

	// mostly low indices so frees and marks land on allocated bits
	task automatic queue_random(input int count);
		request_t r;
		int       pick;
		int       lim;
		int       hi;
		for (int i = 0; i < count; i++) begin
			r.zone = 1'($urandom_range(0, 1));
			lim    = eff_limit(r.zone);
			pick   = $urandom_range(0, 99);
			if (pick < 45) r.kind = OP_ALLOC;
			else if (pick < 70) r.kind = OP_FREE;
			else if (pick < 94) r.kind = OP_MARK;
			else r.kind = OP_NONE;
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				hi    = (lim < 64) ? lim : 64;
				r.idx = INDEX_W'($urandom_range(0, hi));
			end else if (pick < 85) begin
				r.idx = INDEX_W'($urandom);
			end else begin
				r.idx = INDEX_W'(lim - 1 + int'($urandom_range(0, 2)));
			end
			pend_requests.push_back(r);
		end
	endtask

	task automatic cfg_access(input bit wr, input logic sel, input logic [31:0] wdata,
			output logic [31:0] rdata);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= CFG_ADDR_W'({sel, 2'b00});
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_limits(input logic [31:0] ival, input logic [31:0] zval);
		logic [31:0] rd;
		cfg_access(1'b1, REG_INODE_LIMIT, ival, rd);
		inode_lim_reg = ival[INODE_LIMIT_W-1:0];
		cfg_access(1'b1, REG_ZONE_LIMIT, zval, rd);
		zone_lim_reg = zval[ZONE_LIMIT_W-1:0];
		cfg_access(1'b0, REG_INODE_LIMIT, '0, rd);
		if (rd !== 32'(inode_lim_reg)) begin
			$error("inode_limit: expected %0d, got %0d", inode_lim_reg, rd);
			failed = 1'b1;
		end
		cfg_access(1'b0, REG_ZONE_LIMIT, '0, rd);
		if (rd !== 32'(zone_lim_reg)) begin
			$error("zone_limit: expected %0d, got %0d", zone_lim_reg, rd);
			failed = 1'b1;
		end
	endtask

	// sender holds until everything queued has drained
	task automatic settle();
		while (pend_requests.size() != 0 || in_valid || due_outcomes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// request driver: bursts with random gaps
	always @(negedge clk) begin
		bit       hold;
		request_t nxt;
		hold = in_valid;
		if (hold && req_taken) hold = 1'b0;
		if (!hold && arst_n) begin
			if (gap_left > 0) begin
				gap_left--;
			end else if (pend_requests.size() > 0) begin
				nxt        = pend_requests.pop_front();
				hold       = 1'b1;
				op         <= nxt.kind;
				map_select <= nxt.zone;
				index      <= nxt.idx;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
		in_valid <= hold;
	end

	// result receiver stall pattern, with an occasional long hold-off
	always @(negedge clk) begin
		bit s;
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			s = 1'b1;
		end else if (hold_done != hold_req) begin
			hold_done = hold_req;
			hold_left = 400;
			s         = 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode   = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_OPEN:  s = 1'b0;
				RX_LIGHT: s = ($urandom_range(0, 3) == 0);
				RX_HEAVY: s = ($urandom_range(0, 3) != 0);
				default:  s = (rx_cycle % 7) < 3;
			endcase
		end
		out_stall <= s;
	end

	// monitor: check result beats, predict on request beats
	always @(posedge clk) begin
		outcome_t want;
		request_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (due_outcomes.size() == 0) begin
					$error("unexpected result beat: number %0d status %0d", number, status);
					failed = 1'b1;
				end else begin
					want = due_outcomes.pop_front();
					if (number !== want.num) begin
						$error("number: expected %0d, got %0d", want.num, number);
						failed = 1'b1;
					end
					if (status !== want.stat) begin
						$error("status: expected %0d, got %0d", want.stat, status);
						failed = 1'b1;
					end
				end
			end
			req_taken = in_valid && !in_stall;
			if (req_taken) begin
				got.kind = op_t'(op);
				got.zone = map_select;
				got.idx  = index;
				due_outcomes.push_back(predict_outcome(got));
			end
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed corners at reset limits
		queue_req(OP_ALLOC, 1'b0, 0);
		queue_req(OP_ALLOC, 1'b0, 0);
		queue_req(OP_ALLOC, 1'b1, 0);
		queue_req(OP_FREE, 1'b0, 1);
		queue_req(OP_ALLOC, 1'b0, 0);
		queue_req(OP_MARK, 1'b0, 0);
		queue_req(OP_FREE, 1'b0, 0);
		queue_req(OP_MARK, 1'b0, 3);
		queue_req(OP_MARK, 1'b0, 3);
		queue_req(OP_FREE, 1'b0, 100);
		queue_req(OP_MARK, 1'b0, 4095);
		queue_req(OP_FREE, 1'b0, 4095);
		queue_req(OP_MARK, 1'b0, 4096);
		queue_req(OP_FREE, 1'b0, 65535);
		queue_req(OP_MARK, 1'b1, 65535);
		queue_req(OP_FREE, 1'b1, 65535);
		queue_req(OP_MARK, 1'b1, 0);
		queue_req(OP_ALLOC, 1'b1, 0);
		queue_req(OP_NONE, 1'b1, 65535);
		queue_req(OP_NONE, 1'b0, 0);
		queue_req(OP_FREE, 1'b1, 0);
		settle();

		queue_random(250);
		repeat (150) @(negedge clk);
		hold_req++;
		settle();

		// small maps fill up quickly
		set_limits(37, 70);
		queue_random(220);
		settle();

		set_limits(0, 1);
		queue_random(40);
		settle();
		set_limits(1, 0);
		queue_random(40);
		settle();

		// limits beyond the map size clamp to it
		set_limits(8191, 131071);
		queue_random(150);
		repeat (100) @(negedge clk);
		hold_req++;
		settle();

		set_limits($urandom_range(1, 4096), $urandom_range(1, 65536));
		queue_random(150);
		settle();

		if (!failed) $display("dual_bitmap_allocator regression: pass");
		else $display("dual_bitmap_allocator regression: fail");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("dual_bitmap_allocator regression: fail");
		$finish;
	end

endmodule
